// File: sv/chds_pkg.sv
// Shared types, register map and iteration helpers for the colour hue and distance segmenter.
// Has no dependencies; the top level uses it by scoped names.
package chds_pkg;

    // Configuration register map, as word indexes on the APB port.
    localparam int unsigned CfgAddrWidth = 5;
    localparam logic [2:0] REG_TARGET_RED     = 3'd0;
    localparam logic [2:0] REG_TARGET_GREEN   = 3'd1;
    localparam logic [2:0] REG_TARGET_BLUE    = 3'd2;
    localparam logic [2:0] REG_DISTANCE_LIMIT = 3'd3;
    localparam logic [2:0] REG_HUE_HALF_LIMIT = 3'd4;

    // Reset values of the registers.
    localparam logic [7:0] RstTargetRed     = 8'd0;
    localparam logic [7:0] RstTargetGreen   = 8'd0;
    localparam logic [7:0] RstTargetBlue    = 8'd255;
    localparam logic [7:0] RstDistanceLimit = 8'd40;
    localparam logic [7:0] RstHueHalfLimit  = 8'd100;

    // Datapath widths.
    localparam int unsigned NumWidth  = 17;   // hue numerator, up to 360 * 255
    localparam int unsigned SumWidth  = 18;   // sum of three squared differences
    localparam int unsigned RootWidth = 9;    // quotient and root bits
    localparam int unsigned StepsPerStage = 3;

    // Which channel holds the maximum; ties go to red, then green.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [NumWidth-1:0]  rem;
        logic [RootWidth-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [SumWidth-1:0]  rem;
        logic [RootWidth-1:0] root;
    } t_sqrt;

    // Three restoring division steps, producing quotient bits hi, hi-1 and hi-2.
    function automatic t_div div_steps(t_div acc, logic [7:0] den, int unsigned hi);
        t_div                res;
        logic [NumWidth-1:0] trial;
        int unsigned         pos;
        res = acc;
        for (int unsigned j = 0; j < StepsPerStage; j++) begin
            pos   = hi - j;
            trial = NumWidth'({9'd0, den} << pos);
            if (res.rem >= trial) begin
                res.rem      = res.rem - trial;
                res.quo[pos] = 1'b1;
            end
        end
        return res;
    endfunction

    // Three digit-by-digit square root steps, producing root bits hi, hi-1 and hi-2.
    function automatic t_sqrt sqrt_steps(t_sqrt acc, int unsigned hi);
        t_sqrt             res;
        logic [SumWidth:0] trial;
        int unsigned       pos;
        res = acc;
        for (int unsigned j = 0; j < StepsPerStage; j++) begin
            pos   = hi - j;
            trial = (SumWidth+1)'({10'd0, res.root} << (pos + 1))
                  + (SumWidth+1)'(19'd1 << (2 * pos));
            if ({1'b0, res.rem} >= trial) begin
                res.rem       = res.rem - SumWidth'(trial);
                res.root[pos] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: sv/color_hue_distance_segmenter_top.sv
// Top level of the colour hue and distance segmenter: APB registers and a five-stage pipeline.
// Depends on chds_pkg for the register map, types and the division and root step functions.
//
// Usage: RGB pixels enter on the s_axis channel, one transaction per pixel, with
// tdata = {blue, green, red} (red in bits 7:0). Each pixel yields exactly one result
// transaction on m_axis with mask in bit 0, hue_degrees in bits 9:1 and
// color_distance in bits 17:10. The reference colour and both limits are set through
// the APB port and should only be written while no pixel is in flight.
// The pipeline stages are max/min and squares, numerator and limit products,
// then three stages of three division and three root steps each. Throughput is
// one pixel per clock while the receiver accepts results; the division and the square
// root are spread as nine iterations over three pipeline stages.
// Reset (synchronous, active low) empties the pipeline and loads the register
// reset values. When the receiver holds m_axis_tready low with a result waiting,
// the whole pipeline halts and s_axis_tready falls; no pixel is lost or repeated.
module color_hue_distance_segmenter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    // Result output channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // mask [0], hue_degrees [9:1],
                                        // color_distance [17:10], zero [23:18]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [chds_pkg::CfgAddrWidth-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0] r_target_red;
    logic [7:0] r_target_green;
    logic [7:0] r_target_blue;
    logic [7:0] r_distance_limit;
    logic [7:0] r_hue_half_limit;
    logic [2:0] reg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[chds_pkg::CfgAddrWidth-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_red     <= chds_pkg::RstTargetRed;
            r_target_green   <= chds_pkg::RstTargetGreen;
            r_target_blue    <= chds_pkg::RstTargetBlue;
            r_distance_limit <= chds_pkg::RstDistanceLimit;
            r_hue_half_limit <= chds_pkg::RstHueHalfLimit;
        end else if (cfg_write) begin
            unique case (reg_index)
                chds_pkg::REG_TARGET_RED:     r_target_red     <= pwdata[7:0];
                chds_pkg::REG_TARGET_GREEN:   r_target_green   <= pwdata[7:0];
                chds_pkg::REG_TARGET_BLUE:    r_target_blue    <= pwdata[7:0];
                chds_pkg::REG_DISTANCE_LIMIT: r_distance_limit <= pwdata[7:0];
                chds_pkg::REG_HUE_HALF_LIMIT: r_hue_half_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_index)
            chds_pkg::REG_TARGET_RED:     prdata = {24'd0, r_target_red};
            chds_pkg::REG_TARGET_GREEN:   prdata = {24'd0, r_target_green};
            chds_pkg::REG_TARGET_BLUE:    prdata = {24'd0, r_target_blue};
            chds_pkg::REG_DISTANCE_LIMIT: prdata = {24'd0, r_distance_limit};
            chds_pkg::REG_HUE_HALF_LIMIT: prdata = {24'd0, r_hue_half_limit};
            default:                      prdata = 32'd0;
        endcase
    end

    // The whole pipeline advances together unless a result is held at the output.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage A: maximum, minimum, sector, hue difference and squared distances.
    logic [7:0] pix_r, pix_g, pix_b;
    logic [7:0] mx, mn;
    logic [8:0] n_a_diff;
    chds_pkg::t_sector n_a_sec;
    logic [7:0] ad_r, ad_g, ad_b;

    assign pix_r = s_axis_tdata[7:0];
    assign pix_g = s_axis_tdata[15:8];
    assign pix_b = s_axis_tdata[23:16];

    always_comb begin
        mx = pix_r;
        mn = pix_r;
        if (pix_g > mx) mx = pix_g;
        if (pix_b > mx) mx = pix_b;
        if (pix_g < mn) mn = pix_g;
        if (pix_b < mn) mn = pix_b;
        if (pix_r == mx) begin
            n_a_sec  = chds_pkg::SEC_RED;
            n_a_diff = {1'b0, pix_g} - {1'b0, pix_b};
        end else if (pix_g == mx) begin
            n_a_sec  = chds_pkg::SEC_GREEN;
            n_a_diff = {1'b0, pix_b} - {1'b0, pix_r};
        end else begin
            n_a_sec  = chds_pkg::SEC_BLUE;
            n_a_diff = {1'b0, pix_r} - {1'b0, pix_g};
        end
        ad_r = (pix_r > r_target_red)   ? pix_r - r_target_red   : r_target_red - pix_r;
        ad_g = (pix_g > r_target_green) ? pix_g - r_target_green : r_target_green - pix_g;
        ad_b = (pix_b > r_target_blue)  ? pix_b - r_target_blue  : r_target_blue - pix_b;
    end

    logic              r_a_vld;
    logic [8:0]        r_a_diff;
    chds_pkg::t_sector r_a_sec;
    logic [7:0]        r_a_d;
    logic [15:0]       r_a_sq_r, r_a_sq_g, r_a_sq_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_diff <= n_a_diff;
            r_a_sec  <= n_a_sec;
            r_a_d    <= mx - mn;
            r_a_sq_r <= 16'(ad_r) * 16'(ad_r);
            r_a_sq_g <= 16'(ad_g) * 16'(ad_g);
            r_a_sq_b <= 16'(ad_b) * 16'(ad_b);
        end
    end

    // Stage B: hue numerator with wrap, sum of squares and the two limit products.
    logic signed [17:0] num_s;
    logic [15:0]        sec_off;
    logic [chds_pkg::NumWidth-1:0] n_b_num;

    always_comb begin
        case (r_a_sec)
            chds_pkg::SEC_GREEN: sec_off = 16'(r_a_d) * 16'd120;
            chds_pkg::SEC_BLUE:  sec_off = 16'(r_a_d) * 16'd240;
            default:             sec_off = 16'd0;
        endcase
        num_s = $signed({{9{r_a_diff[8]}}, r_a_diff}) * 18'sd60 + $signed({2'b00, sec_off});
        if (num_s < 0) begin
            num_s = num_s + $signed({1'b0, 17'(r_a_d) * 17'd360});
        end
        n_b_num = num_s[chds_pkg::NumWidth-1:0];
    end

    logic                          r_b_vld;
    logic [chds_pkg::NumWidth-1:0] r_b_num;
    logic [7:0]                    r_b_d;
    logic [chds_pkg::SumWidth-1:0] r_b_sum;
    logic [16:0]                   r_b_hue_lim;
    logic [15:0]                   r_b_dist_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_num      <= n_b_num;
            r_b_d        <= r_a_d;
            r_b_sum      <= chds_pkg::SumWidth'(r_a_sq_r) + chds_pkg::SumWidth'(r_a_sq_g)
                          + chds_pkg::SumWidth'(r_a_sq_b);
            r_b_hue_lim  <= 17'({r_hue_half_limit, 1'b0}) * 17'(r_a_d);
            r_b_dist_lim <= 16'(r_distance_limit) * 16'(r_distance_limit);
        end
    end

    // Stage C: limit compares, quotient bits 8..6 and root bits 8..6.
    chds_pkg::t_div  div_c_in, n_c_div;
    chds_pkg::t_sqrt sqrt_c_in, n_c_sqrt;

    always_comb begin
        div_c_in.rem   = r_b_num;
        div_c_in.quo   = '0;
        sqrt_c_in.rem  = r_b_sum;
        sqrt_c_in.root = '0;
        n_c_div  = chds_pkg::div_steps(div_c_in, r_b_d, 8);
        n_c_sqrt = chds_pkg::sqrt_steps(sqrt_c_in, 8);
    end

    logic            r_c_vld;
    chds_pkg::t_div  r_c_div;
    chds_pkg::t_sqrt r_c_sqrt;
    logic [7:0]      r_c_d;
    logic            r_c_grey, r_c_pass, r_c_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_div  <= n_c_div;
            r_c_sqrt <= n_c_sqrt;
            r_c_d    <= r_b_d;
            r_c_grey <= (r_b_d == 8'd0);
            r_c_pass <= (r_b_num > r_b_hue_lim)
                     && (r_b_sum < chds_pkg::SumWidth'(r_b_dist_lim));
            r_c_sat  <= (r_b_sum[chds_pkg::SumWidth-1:16] != 2'd0);
        end
    end

    // Stage D: quotient bits 5..3 and root bits 5..3.
    logic            r_d_vld;
    chds_pkg::t_div  r_d_div;
    chds_pkg::t_sqrt r_d_sqrt;
    logic [7:0]      r_d_d;
    logic            r_d_grey, r_d_pass, r_d_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (adv) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_div  <= chds_pkg::div_steps(r_c_div, r_c_d, 5);
            r_d_sqrt <= chds_pkg::sqrt_steps(r_c_sqrt, 5);
            r_d_d    <= r_c_d;
            r_d_grey <= r_c_grey;
            r_d_pass <= r_c_pass;
            r_d_sat  <= r_c_sat;
        end
    end

    // Stage E: last three bits of each, grey and saturation handling, output register.
    chds_pkg::t_div  n_e_div;
    chds_pkg::t_sqrt n_e_sqrt;

    always_comb begin
        n_e_div  = chds_pkg::div_steps(r_d_div, r_d_d, 2);
        n_e_sqrt = chds_pkg::sqrt_steps(r_d_sqrt, 2);
    end

    logic       r_e_vld;
    logic       r_e_mask;
    logic [8:0] r_e_hue;
    logic [7:0] r_e_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_mask <= r_d_pass;
            r_e_hue  <= r_d_grey ? 9'd0 : n_e_div.quo;
            r_e_dist <= r_d_sat ? 8'd255 : n_e_sqrt.root[7:0];
        end
    end

    assign m_axis_tvalid = r_e_vld;
    assign m_axis_tdata  = {6'd0, r_e_dist, r_e_hue, r_e_mask};

endmodule
